>>> hw/rtl/bmhq_pkg.sv
// shared types and constants for the binary max-heap queue
package bmhq_pkg;

  localparam int HQ_CAPACITY = 256;

  localparam int MODE_W      = 2;
  localparam int KEY_W       = 32;
  localparam int TAG_W       = 16;
  localparam int SLOT_W      = 9;
  localparam int FILL_W      = 9;
  localparam int STAT_W      = 2;
  localparam int ENTRY_W     = KEY_W + TAG_W;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 64;

  // operation codes
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_POP    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } hq_status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_RM_RD1,
    S_RM_DEC,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RD,
    S_DN_RDR,
    S_DN_CMP,
    S_DONE
  } hq_state_t;

  typedef enum logic [2:0] {
    RD_NONE,
    RD_TARGET,
    RD_LAST,
    RD_PARENT,
    RD_LEFT,
    RD_RIGHT
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_CUR,
    WR_PARENT,
    WR_CHILD
  } wr_sel_t;

  typedef struct packed {
    logic    take;
    logic    ins_init;
    logic    rm_init;
    rd_sel_t rd_sel;
    wr_sel_t wr_sel;
    logic    cap_gone;
    logic    cap_last;
    logic    cap_left;
    logic    pos_up;
    logic    pos_dn;
    logic    out_load;
  } hq_cmd_t;

  typedef struct packed {
    logic req_ok;
    logic req_insert;
    logic pos_is_root;
    logic has_left;
    logic has_right;
    logic up_swap;
    logic dn_swap;
    logic rm_move;
    logic rm_up;
    logic out_free;
  } hq_sts_t;

endpackage

>>> hw/rtl/bmhq_ram.sv
// generic single-write, single-read ram with registered read data
module bmhq_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/bmhq_ctrl.sv
// sequencing state machine for heap insert, pop and delete
module bmhq_ctrl import bmhq_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  input  hq_sts_t sts,
  output hq_cmd_t cmd
);

  hq_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.take  = 1'b1;
          state_nxt = S_START;
        end
      end
      S_START: begin
        if (!sts.req_ok) begin
          state_nxt = S_DONE;
        end else if (sts.req_insert) begin
          cmd.ins_init = 1'b1;
          state_nxt    = S_UP_RD;
        end else begin
          cmd.rm_init = 1'b1;
          cmd.rd_sel  = RD_TARGET;
          state_nxt   = S_RM_RD1;
        end
      end
      S_RM_RD1: begin
        cmd.cap_gone = 1'b1;
        cmd.rd_sel   = RD_LAST;
        state_nxt    = S_RM_DEC;
      end
      S_RM_DEC: begin
        cmd.cap_last = 1'b1;
        // removing the last slot leaves nothing to re-sift
        if (!sts.rm_move) begin
          state_nxt = S_DONE;
        end else if (sts.rm_up) begin
          state_nxt = S_UP_RD;
        end else begin
          state_nxt = S_DN_RD;
        end
      end
      S_UP_RD: begin
        if (sts.pos_is_root) begin
          cmd.wr_sel = WR_CUR;
          state_nxt  = S_DONE;
        end else begin
          cmd.rd_sel = RD_PARENT;
          state_nxt  = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (sts.up_swap) begin
          cmd.wr_sel = WR_PARENT;
          cmd.pos_up = 1'b1;
          state_nxt  = S_UP_RD;
        end else begin
          cmd.wr_sel = WR_CUR;
          state_nxt  = S_DONE;
        end
      end
      S_DN_RD: begin
        if (!sts.has_left) begin
          cmd.wr_sel = WR_CUR;
          state_nxt  = S_DONE;
        end else begin
          cmd.rd_sel = RD_LEFT;
          state_nxt  = S_DN_RDR;
        end
      end
      S_DN_RDR: begin
        cmd.cap_left = 1'b1;
        if (sts.has_right) begin
          cmd.rd_sel = RD_RIGHT;
        end
        state_nxt = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (sts.dn_swap) begin
          cmd.wr_sel = WR_CHILD;
          cmd.pos_dn = 1'b1;
          state_nxt  = S_DN_RD;
        end else begin
          cmd.wr_sel = WR_CUR;
          state_nxt  = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/bmhq_dpath.sv
// heap datapath: entry ram, sift position, moving entry and result register
module bmhq_dpath import bmhq_pkg::*; #(
  parameter int CAPACITY = HQ_CAPACITY
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  hq_cmd_t                cmd,
  output hq_sts_t                sts,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int MW = (CW > SLOT_W) ? CW : SLOT_W;

  // request fields
  logic [MODE_W-1:0] in_mode;
  logic [KEY_W-1:0]  in_key;
  logic [TAG_W-1:0]  in_tag;
  logic [SLOT_W-1:0] in_slot;

  assign in_mode = in_tdata[1:0];
  assign in_key  = in_tdata[33:2];
  assign in_tag  = in_tdata[49:34];
  assign in_slot = in_tdata[58:50];

  logic [CW-1:0]    count_r;
  logic [CW-1:0]    pos_r;
  logic [CW-1:0]    slot_r;
  logic             req_insert_r;
  logic             req_pop_r;
  hq_status_t       res_status_r;
  logic [KEY_W-1:0] cur_key_r;
  logic [TAG_W-1:0] cur_tag_r;
  logic [KEY_W-1:0] gone_key_r;
  logic [TAG_W-1:0] gone_tag_r;
  logic [KEY_W-1:0] left_key_r;
  logic [TAG_W-1:0] left_tag_r;
  logic             out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  hq_status_t req_status;

  always_comb begin
    case (in_mode)
      MODE_INSERT: req_status = (count_r == CW'(CAPACITY)) ? ST_FULL : ST_OK;
      MODE_POP:    req_status = (count_r == '0) ? ST_BAD : ST_OK;
      MODE_DELETE: begin
        if (in_slot == '0 || MW'(in_slot) > MW'(count_r)) begin
          req_status = ST_BAD;
        end else begin
          req_status = ST_OK;
        end
      end
      default:     req_status = ST_BAD;
    endcase
  end

  // ram ports
  logic [ENTRY_W-1:0] rdata;
  logic [KEY_W-1:0]   rd_key;
  logic [AW-1:0]      raddr;
  logic [AW-1:0]      waddr;
  logic [ENTRY_W-1:0] wdata;
  logic               we;
  logic [CW:0]        rpos;
  logic [CW:0]        left_pos;
  logic [CW:0]        right_pos;
  logic [CW-1:0]      target_pos;
  logic               child_right;
  logic [KEY_W-1:0]   child_key;

  assign rd_key     = rdata[ENTRY_W-1:TAG_W];
  assign left_pos   = {pos_r, 1'b0};
  assign right_pos  = {pos_r, 1'b1};
  assign target_pos = req_pop_r ? CW'(1) : slot_r;

  always_comb begin
    case (cmd.rd_sel)
      RD_TARGET: rpos = {1'b0, target_pos};
      RD_LAST:   rpos = {1'b0, count_r};
      RD_PARENT: rpos = {2'b00, pos_r[CW-1:1]};
      RD_LEFT:   rpos = left_pos;
      RD_RIGHT:  rpos = right_pos;
      default:   rpos = (CW+1)'(1);
    endcase
  end

  // one-based heap slot to zero-based ram address
  assign raddr = AW'(rpos - (CW+1)'(1));
  assign waddr = AW'(pos_r - CW'(1));

  // right child only when present and strictly larger than the left one
  assign child_right = sts.has_right && ($signed(rd_key) > $signed(left_key_r));
  assign child_key   = child_right ? rd_key : left_key_r;

  always_comb begin
    we    = 1'b1;
    wdata = {cur_key_r, cur_tag_r};
    case (cmd.wr_sel)
      WR_CUR:    wdata = {cur_key_r, cur_tag_r};
      WR_PARENT: wdata = rdata;
      WR_CHILD:  wdata = child_right ? rdata : {left_key_r, left_tag_r};
      default:   we = 1'b0;
    endcase
  end

  bmhq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // status toward the controller
  assign sts.req_ok      = (res_status_r == ST_OK);
  assign sts.req_insert  = req_insert_r;
  assign sts.pos_is_root = (pos_r == CW'(1));
  assign sts.has_left    = (left_pos <= {1'b0, count_r});
  assign sts.has_right   = (left_pos < {1'b0, count_r});
  assign sts.up_swap     = ($signed(cur_key_r) > $signed(rd_key));
  assign sts.dn_swap     = ($signed(cur_key_r) < $signed(child_key));
  assign sts.rm_move     = (pos_r != count_r);
  assign sts.rm_up       = ($signed(rd_key) >= $signed(gone_key_r));
  assign sts.out_free    = !out_valid_r || out_tready;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.ins_init) begin
        count_r <= count_r + CW'(1);
      end else if (cmd.cap_last) begin
        count_r <= count_r - CW'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      req_insert_r <= (in_mode == MODE_INSERT);
      req_pop_r    <= (in_mode == MODE_POP);
      slot_r       <= CW'(in_slot);
      res_status_r <= req_status;
      cur_key_r    <= in_key;
      cur_tag_r    <= in_tag;
      gone_key_r   <= '0;
      gone_tag_r   <= '0;
    end
    if (cmd.ins_init) begin
      pos_r <= count_r + CW'(1);
    end else if (cmd.rm_init) begin
      pos_r <= target_pos;
    end else if (cmd.pos_up) begin
      pos_r <= pos_r >> 1;
    end else if (cmd.pos_dn) begin
      pos_r <= child_right ? CW'(right_pos) : CW'(left_pos);
    end
    if (cmd.cap_gone) begin
      gone_key_r <= rd_key;
      gone_tag_r <= rdata[TAG_W-1:0];
    end
    if (cmd.cap_last) begin
      cur_key_r <= rd_key;
      cur_tag_r <= rdata[TAG_W-1:0];
    end
    if (cmd.cap_left) begin
      left_key_r <= rd_key;
      left_tag_r <= rdata[TAG_W-1:0];
    end
    if (cmd.out_load) begin
      out_data_r <= OUT_TDATA_W'({res_status_r, FILL_W'(count_r), gone_tag_r, gone_key_r});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

>>> hw/rtl/binary_max_heap_queue_unit.sv
// top level of the binary max-heap priority queue
//
//  channel   dir  handshake              payload
//  in_       in   in_tvalid/in_tready    in_tdata: mode, entry_key, entry_tag, slot
//  out_      out  out_tvalid/out_tready  out_tdata: out_key, out_tag, fill_count, status
//
// one request at a time; insert sifts the new entry up, pop and delete replace the
// removed entry with the last one and sift it up or down, levels up to log2(CAPACITY);
// every sift level goes through the single ram read port (compare after each read).
// failed requests skip the sift. no clearing pass after reset.
// a held result does not block the next request until that request finishes.
module binary_max_heap_queue_unit import bmhq_pkg::*; #(
  parameter int CAPACITY = HQ_CAPACITY
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [1:0] mode, [33:2] entry_key, [49:34] entry_tag, [58:50] slot, [63:59] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [31:0] out_key, [47:32] out_tag, [56:48] fill_count, [58:57] status, [63:59] zero
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  hq_cmd_t cmd;
  hq_sts_t sts;

  bmhq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bmhq_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

>>> hw/rtl/bmhq_checker.sv
// port-level checks for the heap queue, bound to the top level
module bmhq_checker import bmhq_pkg::*; #(
  parameter int CAPACITY = HQ_CAPACITY
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // reset empties the result register
  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // one request in flight: no accept on the cycle after an accept
  a_in_single: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted back to back");

  // failed requests carry no entry
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[58:57] != ST_OK |-> out_tdata[47:0] == '0)
    else $error("failed request returned an entry");

  // full status only when the heap holds capacity entries
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[58:57] == ST_FULL |-> out_tdata[56:48] == FILL_W'(CAPACITY))
    else $error("full status with room left");

endmodule

bind binary_max_heap_queue_unit bmhq_checker #(
  .CAPACITY (CAPACITY)
) u_bmhq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
